### hw/rtl/ahrlp_pkg.sv
// Shared types, constants and helper functions for the ASCII hex reply line parser.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package ahrlp_pkg;

  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] LINE_MAX  = 7'd64;
  localparam logic [COUNT_W-1:0] MIN_LINE  = 7'd23;
  localparam logic [COUNT_W-1:0] FIRST_AT  = 7'd7;
  localparam logic [COUNT_W-1:0] SECOND_AT = 7'd15;
  localparam logic [COUNT_W-1:0] FIELD_END = 7'd23;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_CHECKSUM  = 3'd2;
  localparam logic [2:0] ST_NON_HEX   = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic signed [15:0] NO_READING_RESET = 16'sd28;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } line_rec_t;

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

### hw/rtl/ahrlp_front.sv
// Front end: accepts reply bytes, tracks the line, checksum and hex digit fields.
// On a terminator after a non-empty line it classifies the line and pushes one record. Uses ahrlp_pkg.
`timescale 1ns / 1ps

module ahrlp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_byte,
  input  logic                 accept,
  output logic                 push,
  output ahrlp_pkg::line_rec_t push_rec
);
  import ahrlp_pkg::*;

  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]         delayed_sum_r, delayed_sum_nxt;
  logic [7:0]         older_byte_r, older_byte_nxt;
  logic [7:0]         newer_byte_r, newer_byte_nxt;
  logic [31:0]        first_word_r, first_word_nxt;
  logic [31:0]        second_word_r, second_word_nxt;
  logic               bad_digit_r, bad_digit_nxt;

  logic               is_term;
  logic [4:0]         hex;
  logic               sum_ok;
  logic [2:0]         status;

  assign is_term = (in_rx_byte == CHAR_CR) || (in_rx_byte == CHAR_LF);
  assign hex     = hex_value(in_rx_byte);
  assign sum_ok  = (older_byte_r == hex_char(delayed_sum_r[7:4])) &&
                   (newer_byte_r == hex_char(delayed_sum_r[3:0]));

  always_comb begin
    priority if (byte_count_r >= LINE_MAX) begin
      status = ST_TOO_LONG;
    end else if (byte_count_r < MIN_LINE) begin
      status = ST_TOO_SHORT;
    end else if (!sum_ok) begin
      status = ST_CHECKSUM;
    end else if (bad_digit_r) begin
      status = ST_NON_HEX;
    end else begin
      status = ST_OK;
    end
  end

  assign push                 = accept && in_valid && is_term && (byte_count_r != '0);
  assign push_rec.status      = status;
  assign push_rec.first_word  = first_word_r;
  assign push_rec.second_word = second_word_r;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    delayed_sum_nxt = delayed_sum_r;
    older_byte_nxt  = older_byte_r;
    newer_byte_nxt  = newer_byte_r;
    first_word_nxt  = first_word_r;
    second_word_nxt = second_word_r;
    bad_digit_nxt   = bad_digit_r;
    if (accept && in_valid) begin
      if (is_term) begin
        byte_count_nxt  = '0;
        delayed_sum_nxt = '0;
        older_byte_nxt  = '0;
        newer_byte_nxt  = '0;
        first_word_nxt  = '0;
        second_word_nxt = '0;
        bad_digit_nxt   = 1'b0;
      end else if (byte_count_r < LINE_MAX) begin
        // The checksum covers every byte but the newest two.
        if (byte_count_r >= 7'd2) begin
          delayed_sum_nxt = delayed_sum_r + older_byte_r;
        end
        older_byte_nxt = newer_byte_r;
        newer_byte_nxt = in_rx_byte;
        if (byte_count_r >= FIRST_AT && byte_count_r < FIELD_END) begin
          if (!hex[4]) begin
            bad_digit_nxt = 1'b1;
          end
          if (byte_count_r < SECOND_AT) begin
            first_word_nxt = {first_word_r[27:0], hex[3:0]};
          end else begin
            second_word_nxt = {second_word_r[27:0], hex[3:0]};
          end
        end
        byte_count_nxt = byte_count_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      delayed_sum_r <= '0;
      older_byte_r  <= '0;
      newer_byte_r  <= '0;
      first_word_r  <= '0;
      second_word_r <= '0;
      bad_digit_r   <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      delayed_sum_r <= delayed_sum_nxt;
      older_byte_r  <= older_byte_nxt;
      newer_byte_r  <= newer_byte_nxt;
      first_word_r  <= first_word_nxt;
      second_word_r <= second_word_nxt;
      bad_digit_r   <= bad_digit_nxt;
    end
  end

endmodule

### hw/rtl/ahrlp_queue.sv
// Short register queue of classified line records between front and back end.
// Uses ahrlp_pkg for the record type and depth.
`timescale 1ns / 1ps

module ahrlp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ahrlp_pkg::line_rec_t push_rec,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output ahrlp_pkg::line_rec_t head_rec
);
  import ahrlp_pkg::*;

  line_rec_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_rec  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/ahrlp_back.sv
// Back end: turns the two hex words of a record into saturated tenths values.
// Two register stages: float unpack and shift, then Q12.24 scaling and compare. Uses ahrlp_pkg.
`timescale 1ns / 1ps

module ahrlp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_valid,
  input  ahrlp_pkg::line_rec_t rec,
  output logic                 rec_pop,
  input  logic                 cfg_wr_en,
  input  logic signed [15:0]   cfg_no_reading_code,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic signed [15:0]   out_first_temp,
  output logic signed [15:0]   out_second_temp,
  output logic                 out_first_missing,
  output logic                 out_second_missing
);
  import ahrlp_pkg::*;

  typedef struct packed {
    logic        nan;
    logic        sat;
    logic        neg;
    logic [35:0] mag;
  } dec_t;

  function automatic dec_t unpack_word(input logic [31:0] w);
    logic [31:0] bits;
    logic [7:0]  ex;
    logic [35:0] sig;
    dec_t        d;
    bits  = swap_bytes(w);
    ex    = bits[30:23];
    sig   = {13'd0, bits[22:0]} | 36'h000800000;
    d.neg = bits[31];
    d.nan = 1'b0;
    d.sat = 1'b0;
    d.mag = '0;
    if (ex == 8'hFF) begin
      if (bits[22:0] != 23'd0) begin
        d.nan = 1'b1;
      end else begin
        d.sat = 1'b1;
      end
    end else if (ex >= 8'd139) begin
      d.sat = 1'b1;
    end else if (ex != 8'd0) begin
      if (ex >= 8'd126) begin
        d.mag = sig << (ex - 8'd126);
      end else if (ex > 8'd102) begin
        d.mag = sig >> (8'd126 - ex);
      end
    end
    return d;
  endfunction

  // trunc((q + 0.01) * 10) with q in Q12.24, then 16-bit saturation.
  function automatic logic signed [15:0] scale_value(input dec_t d);
    logic signed [37:0] x;
    logic signed [41:0] xe;
    logic signed [41:0] p;
    logic signed [41:0] t;
    logic signed [15:0] r;
    x  = $signed({2'b00, d.mag});
    if (d.neg) begin
      x = -x;
    end
    x  = x + 38'sd167772;
    xe = {{4{x[37]}}, x};
    p  = (xe <<< 3) + (xe <<< 1);
    if (p[41]) begin
      p = p + 42'sd16777215;
    end
    t = p >>> 24;
    if (d.nan) begin
      r = 16'sd0;
    end else if (d.sat) begin
      r = d.neg ? 16'sh8000 : 16'sh7FFF;
    end else if (t > 42'sd32767) begin
      r = 16'sh7FFF;
    end else if (t < -42'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  logic signed [15:0] code_r;
  logic               s1_valid_r;
  logic [2:0]         s1_status_r;
  dec_t               s1_first_r, s1_second_r;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic signed [15:0] first_r, second_r;
  logic               first_miss_r, second_miss_r;

  logic               out_advance, s1_take;
  logic signed [15:0] first_val, second_val;
  logic               ok;

  assign out_advance = !out_valid_r || out_ready;
  assign s1_take     = !s1_valid_r || out_advance;
  assign rec_pop     = s1_take && rec_valid;

  assign ok         = (s1_status_r == ST_OK);
  assign first_val  = ok ? scale_value(s1_first_r) : 16'sd0;
  assign second_val = ok ? scale_value(s1_second_r) : 16'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= NO_READING_RESET;
    end else if (cfg_wr_en) begin
      code_r <= cfg_no_reading_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= rec_valid;
      end
      if (out_advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_status_r <= rec.status;
      s1_first_r  <= unpack_word(rec.first_word);
      s1_second_r <= unpack_word(rec.second_word);
    end
    if (out_advance && s1_valid_r) begin
      out_status_r  <= s1_status_r;
      first_r       <= first_val;
      second_r      <= second_val;
      first_miss_r  <= ok && (first_val == code_r);
      second_miss_r <= ok && (second_val == code_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_first_temp     = first_r;
  assign out_second_temp    = second_r;
  assign out_first_missing  = first_miss_r;
  assign out_second_missing = second_miss_r;

endmodule

### hw/rtl/ascii_hex_reply_line_parser_core.sv
// Top level of the ASCII hex reply line parser.
// Instantiates ahrlp_front, ahrlp_queue and ahrlp_back; uses ahrlp_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready, in_rx_byte): one reply byte per transaction.
//   A CR or LF byte ends the line; an empty line produces no result.
//   Output channel (out_valid/out_ready): one result per terminated non-empty
//   line with status, two temperatures in tenths and two no-reading flags.
//   Configuration: cfg_wr_en writes cfg_no_reading_code in the same cycle.
// Throughput: one byte per cycle while in_ready is high. The front end tracks
//   the line as each byte is accepted; conversion happens once per line in a two-stage back end.
// Path: after the terminator's transaction the record is written into the
//   queue entry, then passes the float unpack stage and the scaling and
//   output register before out_valid rises.
// Stalls: while out_ready is low the result is held and the back end stops;
//   the two-entry record queue then fills and in_ready drops when it is full.
// Reset: synchronous, active low on rst_n. Line state is cleared, the queue and
//   pipeline are emptied and the no-reading code returns to 28.
module ascii_hex_reply_line_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_first_temp,
  output logic signed [15:0] out_second_temp,
  output logic               out_first_missing,
  output logic               out_second_missing,
  input  logic               cfg_wr_en,
  input  logic signed [15:0] cfg_no_reading_code
);
  import ahrlp_pkg::*;

  logic      push, pop, full, not_empty;
  line_rec_t push_rec, head_rec;

  assign in_ready = !full;

  ahrlp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .accept     (in_ready),
    .push       (push),
    .push_rec   (push_rec)
  );

  ahrlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_rec  (head_rec)
  );

  ahrlp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rec_valid           (not_empty),
    .rec                 (head_rec),
    .rec_pop             (pop),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_no_reading_code (cfg_no_reading_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_first_temp      (out_first_temp),
    .out_second_temp     (out_second_temp),
    .out_first_missing   (out_first_missing),
    .out_second_missing  (out_second_missing)
  );

endmodule
